>>> src/lss_pkg.sv
// Shared types and constants for the LIFO stack with search.
// Used by lifo_stack_with_search and its testbench; depends on nothing else.
package lss_pkg;

  // Default sizes of the stack.
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the port fields.
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // Operation codes.
  typedef enum logic [2:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_PEEK   = 3'd2,
    FN_SEARCH = 3'd3,
    FN_CLEAR  = 3'd4
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SRCH
  } state_t;

  // Request word.
  typedef struct packed {
    func_t              func;
    logic [VALUE_W-1:0] value;
  } req_t;

  // Result word.
  typedef struct packed {
    logic [VALUE_W-1:0] data_out;
    logic               found;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               empty_flag;
  } res_t;

endpackage

>>> src/lss_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/lifo_stack_with_search.sv
// Top level of the LIFO stack with search: controller around one stack RAM.
// Depends on lss_pkg and lss_ram.
//
// Usage:
//   A request word (in_req: func, value) is taken at a rising edge where start
//   is high and busy is low. Every request gives exactly one result word on
//   out_res, shown for one cycle with out_valid high. The receiver cannot
//   stall; results are never held.
// Flow by operation:
//   Push, clear and unused codes: result registered at the edge that takes the
//   request; busy stays low, so a new request may follow every cycle.
//   Pop and peek: the top entry is read through the RAM's registered port,
//   then the result is registered from the read state, which keeps busy high.
//   Search: entries are walked one per cycle through the single RAM read port
//   from the bottom while busy is high; the result is registered from the
//   last compare; it stops early on the first match. On an empty stack
//   search does not go busy and answers like a push.
// Reset:
//   Synchronous, active low. The count goes to zero; the RAM is not cleared,
//   as only entries below the count are ever used for a result.
// All writes happen at the edge the request is taken, and no read for a result
// shares an edge with a write, so no result mixes a read and a write to one entry.
module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output res_t out_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_r, out_nxt;

  logic                  accept;
  logic                  full;
  logic                  stack_empty;
  logic [DATA_WIDTH-1:0] in_word;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  hit;

  assign accept      = start && !busy;
  assign full        = (count_r == CW'(DEPTH));
  assign stack_empty = (count_r == '0);
  assign in_word     = DATA_WIDTH'(in_req.value);
  assign hit         = (ram_rdata == key_r);

  lss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state, RAM control and result word.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_raddr     = ptr_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt      = 1'b1;
          out_nxt.data_out   = '0;
          out_nxt.found      = 1'b0;
          out_nxt.status     = STAT_OK;
          unique case (in_req.func)
            FN_PUSH: begin
              if (full) begin
                out_nxt.status = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            FN_POP, FN_PEEK: begin
              if (stack_empty) begin
                out_nxt.status = STAT_EMPTY;
              end else begin
                // Read the top entry; result comes from the read state.
                ram_raddr     = AW'(count_r - CW'(1));
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                if (in_req.func == FN_POP) begin
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            FN_SEARCH: begin
              if (!stack_empty) begin
                // Start the walk at the bottom entry.
                ram_raddr     = '0;
                ptr_nxt       = CW'(1);
                key_nxt       = in_word;
                out_valid_nxt = 1'b0;
                state_nxt     = S_SRCH;
              end
            end
            FN_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          out_nxt.count      = COUNT_W'(count_nxt);
          out_nxt.empty_flag = (count_nxt == '0);
        end
      end
      S_READ: begin
        // Hand out the word read from the top.
        out_valid_nxt      = 1'b1;
        out_nxt.data_out   = VALUE_W'(ram_rdata);
        out_nxt.found      = 1'b0;
        out_nxt.status     = STAT_OK;
        out_nxt.count      = COUNT_W'(count_r);
        out_nxt.empty_flag = stack_empty;
        state_nxt          = S_IDLE;
      end
      S_SRCH: begin
        // Compare the entry read last cycle; finish on a match or at the top.
        if (hit || (ptr_r == count_r)) begin
          out_valid_nxt      = 1'b1;
          out_nxt.data_out   = '0;
          out_nxt.found      = hit;
          out_nxt.status     = STAT_OK;
          out_nxt.count      = COUNT_W'(count_r);
          out_nxt.empty_flag = stack_empty;
          state_nxt          = S_IDLE;
        end else begin
          ram_raddr = ptr_r[AW-1:0];
          ptr_nxt   = ptr_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // The stack never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stack count above depth");

  // A shown result's empty flag matches the live count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.empty_flag == (count_r == '0)))
    else $error("empty flag disagrees with count");

  // A push gives its result in the next cycle.
  a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.func == FN_PUSH)) |=> out_valid_r)
    else $error("push result missing");

  // The search walk stays inside the filled part of the stack.
  a_search_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> ((ptr_r != '0) && (ptr_r <= count_r)))
    else $error("search pointer out of range");

endmodule

>>> test/testbench.sv
// Self-checking testbench for lifo_stack_with_search: drives push, pop, peek, search,
// clear and spare codes, predicts every result word and compares it field by field.
// Depends on lss_pkg and the block's RTL.
module testbench
  import lss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 800;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 10;
  localparam int POOL_SIZE   = 8;
  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_MID = 3'd6;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;

  // Shadow stack: predicts each result word and holds the ones still due.
  class stack_scoreboard;
    logic [VALUE_W-1:0] entries [DEPTH_DEF];
    int unsigned fill;
    res_t due_results [$];
    int mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Apply one accepted request word to the shadow stack and queue its result.
    function void note_request(req_t req);
      res_t r;
      r = '0;
      r.status = STAT_OK;
      case (req.func)
        FN_PUSH: begin
          if (fill >= DEPTH_DEF) begin
            r.status = STAT_FULL;
          end else begin
            entries[fill] = req.value;
            fill++;
          end
        end
        FN_POP: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            fill--;
            r.data_out = entries[fill];
          end
        end
        FN_PEEK: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.data_out = entries[fill - 1];
          end
        end
        FN_SEARCH: begin
          // only live entries take part
          for (int i = 0; i < fill; i++) begin
            if (entries[i] == req.value) r.found = 1'b1;
          end
        end
        FN_CLEAR: begin
          fill = 0;
        end
        default: begin
        end
      endcase
      r.count = COUNT_W'(fill);
      r.empty_flag = (fill == 0);
      due_results = {due_results, r};
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one result word with the oldest prediction.
    task check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result word with none due: %p", got));
      end else begin
        want = due_results.pop_front();
        if (got.data_out !== want.data_out)
          report($sformatf("data_out %h, want %h", got.data_out, want.data_out));
        if (got.found !== want.found)
          report($sformatf("found %b, want %b", got.found, want.found));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.count !== want.count)
          report($sformatf("count %0d, want %0d", got.count, want.count));
        if (got.empty_flag !== want.empty_flag)
          report($sformatf("empty_flag %b, want %b", got.empty_flag, want.empty_flag));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  res_t out_res;

  stack_scoreboard sb = new();
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];
  int sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  lifo_stack_with_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always #6 clk = ~clk;

  // Check results first, then note the word taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_res);
      if (start && !busy) sb.note_request(in_req);
    end
  end

  // Stop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(logic [2:0] code, logic [VALUE_W-1:0] v);
    req_t req;
    req.func = func_t'(code);
    req.value = v;
    @(negedge clk);
    start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Drop start for a pause of length n and put noise on the request bus.
  task automatic pause_cycles(int n);
    req_t noise;
    if (n > 0) begin
      noise.func = func_t'(3'($urandom));
      noise.value = $urandom;
      @(negedge clk);
      start <= 1'b0;
      in_req <= noise;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return;
    if (r < 90) pause_cycles($urandom_range(1, 3));
    else pause_cycles($urandom_range(8, 40));
  endtask

  // Hold off until every predicted word has arrived.
  task automatic wait_drained();
    pause_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 50) return '0;
    if (r < 55) return '1;
    if (r < 60) return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
    return $urandom;
  endfunction

  // One stretch of random operations, biased toward push or pop.
  task automatic run_segment(int len, int push_pct, int pop_pct);
    int r;
    int k;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 99);
      if (r < push_pct) send_word(FN_PUSH, pick_value());
      else if (r < push_pct + pop_pct) send_word(FN_POP, pick_value());
      else if (k < 45) send_word(FN_SEARCH, pick_value());
      else if (k < 78) send_word(FN_PEEK, pick_value());
      else if (k < 90) send_word(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), pick_value());
      else send_word(FN_CLEAR, pick_value());
      random_gap();
    end
  endtask

  initial begin
    int mode;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty cases, extremes, hit and miss, spare codes, clear.
    send_word(FN_POP, 32'h0);
    send_word(FN_PEEK, 32'hFFFF_FFFF);
    send_word(FN_SEARCH, 32'h0);
    send_word(FN_PUSH, 32'h0);
    send_word(FN_PUSH, 32'hFFFF_FFFF);
    send_word(FN_PUSH, 32'h8000_0001);
    send_word(FN_PEEK, 32'h0);
    send_word(FN_SEARCH, 32'hFFFF_FFFF);
    send_word(FN_SEARCH, 32'h0);
    send_word(FN_SEARCH, 32'h1234_5678);
    send_word(FN_POP, 32'h0);
    send_word(FN_SPARE_LO, 32'hFFFF_FFFF);
    send_word(FN_SPARE_MID, 32'h0);
    send_word(FN_SPARE_HI, 32'h5555_5555);
    send_word(FN_CLEAR, 32'h0);
    send_word(FN_POP, 32'h0);
    send_word(FN_SEARCH, 32'h0);
    send_word(FN_PUSH, 32'hA5A5_A5A5);
    // stale word above the count must not match
    send_word(FN_SEARCH, 32'hFFFF_FFFF);
    send_word(FN_PEEK, 32'h0);
    send_word(FN_POP, 32'h0);
    send_word(FN_PEEK, 32'h0);
    wait_drained();

    // Fill past full with random words, then probe the full stack.
    calm = 1'b1;
    for (int i = 0; i < 70; i++) send_word(FN_PUSH, pick_value());
    calm = 1'b0;
    for (int i = 0; i < 6; i++) begin
      send_word(FN_SEARCH, pick_value());
      random_gap();
    end
    send_word(FN_PEEK, '0);

    // Random stretches: fill, drain and mixed, some without gaps.
    while (sent < ITEM_TARGET) begin
      mode = $urandom_range(0, 2);
      calm = ($urandom_range(0, 4) == 0);
      case (mode)
        0: run_segment($urandom_range(20, 100), 70, 10);
        1: run_segment($urandom_range(20, 100), 10, 70);
        default: run_segment($urandom_range(20, 60), 35, 30);
      endcase
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    calm = 1'b0;

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
